// ===== design/stereo_biquad_cascade_equalizer_core_defines.svh =====
`ifndef STEREO_BIQUAD_CASCADE_EQUALIZER_CORE_DEFINES_SVH
`define STEREO_BIQUAD_CASCADE_EQUALIZER_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define SBEQ_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define SBEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sbeq_pkg.sv =====
package sbeq_pkg;

   localparam int PCM_W              = 16;
   localparam int SIG_W              = 48;
   localparam int SIG_FRAC           = 24;
   localparam int COEF_W             = 32;
   localparam int GAIN_W             = 16;
   localparam int GAIN_FRAC          = 15;
   localparam int MASK_W             = 8;
   localparam int CLIP_W             = 32;
   localparam int NUM_SLOTS          = 5;
   localparam int SLOT_W             = 3;
   localparam int STAGE_W            = 3;
   localparam int KIND_W             = 2;
   localparam int CSR_IDX_W          = 3;
   localparam int CSR_DATA_W         = 16;
   localparam int DEF_STAGES         = 8;
   localparam int DEF_COEF_FRAC_BITS = 26;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_FRAME = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COEF  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   // coefficient slots
   localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

   // order in which a cell runs its five products
   localparam logic [SLOT_W-1:0] STEP_SLOT [NUM_SLOTS] =
      '{SLOT_B0, SLOT_B1, SLOT_A1, SLOT_B2, SLOT_A2};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_EQ_ENABLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PREAMP      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_MASK   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_MASK  = 3'd4;

   localparam logic [1:0] MODE_STEREO = 2'd0;
   localparam logic [1:0] MODE_MONO   = 2'd1;
   localparam logic [1:0] MODE_LEFT   = 2'd2;
   localparam logic [1:0] MODE_RIGHT  = 2'd3;

   localparam logic signed [SIG_W-1:0] S_MAX = {1'b0, {(SIG_W-1){1'b1}}};
   localparam logic signed [SIG_W-1:0] S_MIN = {1'b1, {(SIG_W-1){1'b0}}};

   // sample handed from one cell to the next
   typedef struct packed {
      logic                    go;
      logic signed [SIG_W-1:0] x;
   } sbeq_link_type;

   // coefficient write and delay clear broadcast to all cells
   typedef struct packed {
      logic                     we;
      logic                     ch;
      logic [STAGE_W-1:0]       stage;
      logic [SLOT_W-1:0]        slot;
      logic signed [COEF_W-1:0] value;
      logic                     clear;
   } sbeq_cwr_type;

endpackage

// ===== design/sbeq_if.sv =====
interface sbeq_req_if import sbeq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [PCM_W-1:0]  left_in;
   logic signed [PCM_W-1:0]  right_in;
   logic                     coef_channel;
   logic [STAGE_W-1:0]       coef_stage;
   logic [SLOT_W-1:0]        coef_slot;
   logic signed [COEF_W-1:0] coef_value;

   modport source (output valid, kind, left_in, right_in, coef_channel, coef_stage,
                   coef_slot, coef_value, input ready);
   modport sink   (input valid, kind, left_in, right_in, coef_channel, coef_stage,
                   coef_slot, coef_value, output ready);
endinterface

interface sbeq_rsp_if import sbeq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [PCM_W-1:0] left_out;
   logic signed [PCM_W-1:0] right_out;
   logic                    left_clipped;
   logic                    right_clipped;
   logic [CLIP_W-1:0]       clip_total;

   modport source (output valid, left_out, right_out, left_clipped, right_clipped,
                   clip_total, input ready);
   modport sink   (input valid, left_out, right_out, left_clipped, right_clipped,
                   clip_total, output ready);
endinterface

interface sbeq_csr_if import sbeq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/sbeq_cell.sv =====
module sbeq_cell import sbeq_pkg::*; #(
   parameter int CH             = 0,
   parameter int ST             = 0,
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  sbeq_cwr_type  cwr,
   input  logic          enable,
   input  sbeq_link_type link_in,
   output sbeq_link_type link_out,
   output logic          busy
);

   localparam int CFB    = COEF_FRAC_BITS;
   localparam int HI_W   = SIG_W - CFB;
   localparam int LO_W   = COEF_W + CFB + 1;
   localparam int RLO_W  = LO_W - CFB;
   localparam int PROD_W = COEF_W + HI_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int STEP_W = $clog2(NUM_SLOTS);
   localparam logic [LO_W-1:0] RND = LO_W'(1) << (CFB - 1);

   logic signed [COEF_W-1:0] coef_ff [NUM_SLOTS];
   logic                     busy_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [1:0]               phase_ff;
   logic signed [SIG_W-1:0]  x_ff, y_ff, z1_ff, z2_ff, out_ff;
   logic                     go_ff;
   logic signed [LO_W-1:0]   plo_ff;
   logic signed [PROD_W-1:0] phi_ff;
   logic signed [RLO_W-1:0]  rlo_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   logic [SLOT_W-1:0]        slot_sel;
   logic signed [COEF_W-1:0] coef;
   logic signed [SIG_W-1:0]  opnd;
   logic [CFB-1:0]           lo;
   logic signed [HI_W-1:0]   hi;
   logic [LO_W-1:0]          rnd_sum;
   logic signed [ACC_W-1:0]  prod;

   function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] a);
      logic signed [SIG_W-1:0] r;
      if (a > ACC_W'(S_MAX)) begin
         r = S_MAX;
      end else if (a < ACC_W'(S_MIN)) begin
         r = S_MIN;
      end else begin
         r = a[SIG_W-1:0];
      end
      return r;
   endfunction

   // select the coefficient and operand of the current product
   assign slot_sel = STEP_SLOT[step_ff];
   assign coef     = coef_ff[slot_sel];
   assign opnd     = (slot_sel == SLOT_A1 || slot_sel == SLOT_A2) ? y_ff : x_ff;
   assign lo       = opnd[CFB-1:0];
   assign hi       = opnd[SIG_W-1:CFB];
   assign rnd_sum  = plo_ff + RND;
   assign prod     = ACC_W'(phi_ff) + ACC_W'(rlo_ff);

   // store a coefficient addressed to this cell
   always_ff @(posedge clock) begin
      if (cwr.we && cwr.ch == 1'(CH) && int'(cwr.stage) == ST && cwr.slot < NUM_SLOTS) begin
         coef_ff[cwr.slot] <= cwr.value;
      end
   end

   // pulse the link when a section finishes or is passed over
   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else if (link_in.go) begin
         go_ff <= !enable;
      end else begin
         go_ff <= busy_ff && phase_ff[1] && slot_sel == SLOT_A2;
      end
   end

   // run the five products of one section, each through a low, high and accumulate phase
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= '0;
         phase_ff <= '0;
         z1_ff    <= '0;
         z2_ff    <= '0;
      end else begin
         if (cwr.clear) begin
            z1_ff <= '0;
            z2_ff <= '0;
         end
         if (link_in.go) begin
            if (enable) begin
               busy_ff  <= 1'b1;
               x_ff     <= link_in.x;
               step_ff  <= '0;
               phase_ff <= '0;
            end else begin
               out_ff <= link_in.x;
            end
         end else if (busy_ff) begin
            case (phase_ff)
               2'd0: begin
                  plo_ff   <= coef * $signed({1'b0, lo});
                  phase_ff <= 2'd1;
               end
               2'd1: begin
                  phi_ff   <= coef * hi;
                  rlo_ff   <= $signed(rnd_sum[LO_W-1:CFB]);
                  phase_ff <= 2'd2;
               end
               default: begin
                  phase_ff <= 2'd0;
                  step_ff  <= step_ff + 1'b1;
                  case (slot_sel)
                     SLOT_B0: y_ff   <= sat_sig(prod + ACC_W'(z1_ff));
                     SLOT_B1: acc_ff <= prod + ACC_W'(z2_ff);
                     SLOT_A1: z1_ff  <= sat_sig(acc_ff - prod);
                     SLOT_B2: acc_ff <= prod;
                     default: begin
                        z2_ff   <= sat_sig(acc_ff - prod);
                        busy_ff <= 1'b0;
                        out_ff  <= y_ff;
                     end
                  endcase
               end
            endcase
         end
      end
   end

   assign link_out.go = go_ff;
   assign link_out.x  = out_ff;
   assign busy        = busy_ff;

endmodule

// ===== design/stereo_biquad_cascade_equalizer_core.sv =====
// Channel | Dir | Carries
// req_ch  | in  | sample frame, coefficient write or delay clear
// rsp_ch  | out | processed stereo sample, clip flags, clip total
// csr_ch  | in  | register index and write data, always ready
//
// A frame passes through the preamp state, both rows of sections and the
// done state; each active section runs its five products one after another,
// each as a low-half and high-half multiply; inactive ones pass the sample on.
// Coefficient writes and delay clears are applied when taken and give no result.
// Reset clears registers, delay states and the clip count; coefficients hold
// nothing until written. A stalled result holds the next frame in its last state.
`include "stereo_biquad_cascade_equalizer_core_defines.svh"

module stereo_biquad_cascade_equalizer_core import sbeq_pkg::*; #(
   parameter int STAGES         = DEF_STAGES,
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
   input logic   clock,
   input logic   reset,
   sbeq_req_if.sink   req_ch,
   sbeq_rsp_if.source rsp_ch,
   sbeq_csr_if.sink   csr_ch
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PRE  = 2'd1;
   localparam logic [1:0] S_RUN  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;
   localparam int SRC_W  = PCM_W + 1;
   localparam int PREP_W = SRC_W + GAIN_W + 1;
   localparam int PRE_SH = SIG_FRAC - 1 - GAIN_FRAC;
   localparam int SRC_SH = SIG_FRAC - 1;
   localparam logic signed [SIG_W-1:0] OUT_MAX = SIG_W'(32767) << SIG_FRAC;
   localparam logic signed [SIG_W-1:0] OUT_MIN = -(OUT_MAX + (SIG_W'(1) << SIG_FRAC));
   localparam logic [SIG_FRAC-1:0] HALF = SIG_FRAC'(1) << (SIG_FRAC - 1);

   logic                    eq_ff;
   logic [1:0]              mode_ff;
   logic [GAIN_W-1:0]       gain_ff;
   logic [MASK_W-1:0]       lmask_ff, rmask_ff;
   logic [1:0]              state_ff;
   logic signed [SRC_W-1:0] sl_ff, sr_ff;
   logic                    ldone_ff, rdone_ff;
   logic signed [SIG_W-1:0] ly_ff, ry_ff;
   logic [CLIP_W-1:0]       clip_ff;
   logic                    rsp_valid_ff;
   logic signed [PCM_W-1:0] lout_ff, rout_ff;
   logic                    lclip_ff, rclip_ff;

   logic                    req_take, rsp_free;
   logic signed [SRC_W-1:0] sl_in, sr_in;
   logic signed [PREP_W-1:0] lpre, rpre;
   logic [PCM_W:0]          lres, rres;
   logic [CLIP_W:0]         clip_sum;
   sbeq_cwr_type            cwr;
   sbeq_link_type           lnk [2][STAGES+1];
   logic                    en [2][STAGES];
   logic [2*STAGES-1:0]     cell_busy;

   // round half to even and saturate; top bit is the clip flag
   function automatic logic [PCM_W:0] round_sat(input logic signed [SIG_W-1:0] v);
      logic [PCM_W-1:0] q;
      logic             inc;
      logic [PCM_W:0]   r;
      q   = v[SIG_FRAC+PCM_W-1:SIG_FRAC];
      inc = (v[SIG_FRAC-1:0] > HALF) || (v[SIG_FRAC-1:0] == HALF && q[0]);
      if (v > OUT_MAX) begin
         r = {1'b1, 1'b0, {(PCM_W-1){1'b1}}};
      end else if (v < OUT_MIN) begin
         r = {1'b1, 1'b1, {(PCM_W-1){1'b0}}};
      end else begin
         r = {1'b0, q + PCM_W'(inc)};
      end
      return r;
   endfunction

   // write configuration registers
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         eq_ff    <= 1'b0;
         mode_ff  <= MODE_STEREO;
         gain_ff  <= GAIN_W'(32768);
         lmask_ff <= '0;
         rmask_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_EQ_ENABLE:  eq_ff    <= csr_ch.data[0];
            REG_CHANNEL:    mode_ff  <= csr_ch.data[1:0];
            REG_PREAMP:     gain_ff  <= csr_ch.data[GAIN_W-1:0];
            REG_LEFT_MASK:  lmask_ff <= csr_ch.data[MASK_W-1:0];
            REG_RIGHT_MASK: rmask_ff <= csr_ch.data[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // broadcast coefficient writes and delay clears to the cells
   assign cwr.we    = req_take && req_ch.kind == KIND_COEF;
   assign cwr.clear = req_take && req_ch.kind == KIND_CLEAR;
   assign cwr.ch    = req_ch.coef_channel;
   assign cwr.stage = req_ch.coef_stage;
   assign cwr.slot  = req_ch.coef_slot;
   assign cwr.value = req_ch.coef_value;

   // pick channel sources, in units of half an LSB
   always_comb begin
      unique case (mode_ff)
         MODE_MONO: begin
            sl_in = SRC_W'(req_ch.left_in) + SRC_W'(req_ch.right_in);
            sr_in = sl_in;
         end
         MODE_LEFT: begin
            sl_in = SRC_W'(req_ch.left_in) <<< 1;
            sr_in = sl_in;
         end
         MODE_RIGHT: begin
            sl_in = SRC_W'(req_ch.right_in) <<< 1;
            sr_in = sl_in;
         end
         default: begin
            sl_in = SRC_W'(req_ch.left_in) <<< 1;
            sr_in = SRC_W'(req_ch.right_in) <<< 1;
         end
      endcase
   end

   // apply preamp gain; low product bits are zero so rounding drops out
   assign lpre = sl_ff * $signed({1'b0, gain_ff});
   assign rpre = sr_ff * $signed({1'b0, gain_ff});

   assign lnk[0][0].go = (state_ff == S_PRE);
   assign lnk[1][0].go = (state_ff == S_PRE);
   assign lnk[0][0].x  = eq_ff ? (SIG_W'(lpre) <<< PRE_SH) : (SIG_W'(sl_ff) <<< SRC_SH);
   assign lnk[1][0].x  = eq_ff ? (SIG_W'(rpre) <<< PRE_SH) : (SIG_W'(sr_ff) <<< SRC_SH);

   // two rows of biquad sections
   for (genvar c = 0; c < 2; c++) begin : g_row
      for (genvar s = 0; s < STAGES; s++) begin : g_stage
         if (s < MASK_W) begin : g_en
            assign en[c][s] = eq_ff && ((c == 0) ? lmask_ff[s] : rmask_ff[s]);
         end else begin : g_off
            assign en[c][s] = 1'b0;
         end
         sbeq_cell #(
            .CH             (c),
            .ST             (s),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .cwr      (cwr),
            .enable   (en[c][s]),
            .link_in  (lnk[c][s]),
            .link_out (lnk[c][s+1]),
            .busy     (cell_busy[c*STAGES+s])
         );
      end
   end

   assign lres     = round_sat(ly_ff);
   assign rres     = round_sat(ry_ff);
   assign clip_sum = {1'b0, clip_ff} + CLIP_W'(lres[PCM_W]) + CLIP_W'(rres[PCM_W]);

   // sequence one frame
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ldone_ff     <= 1'b0;
         rdone_ff     <= 1'b0;
         clip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a new result or drop the one just taken
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take && req_ch.kind == KIND_FRAME) begin
                  sl_ff    <= sl_in;
                  sr_ff    <= sr_in;
                  state_ff <= S_PRE;
               end
            end
            S_PRE: state_ff <= S_RUN;
            S_RUN: begin
               if (lnk[0][STAGES].go) begin
                  ldone_ff <= 1'b1;
                  ly_ff    <= lnk[0][STAGES].x;
               end
               if (lnk[1][STAGES].go) begin
                  rdone_ff <= 1'b1;
                  ry_ff    <= lnk[1][STAGES].x;
               end
               if (ldone_ff && rdone_ff) begin
                  state_ff <= S_DONE;
               end
            end
            default: begin
               if (rsp_free) begin
                  lout_ff      <= lres[PCM_W-1:0];
                  rout_ff      <= rres[PCM_W-1:0];
                  lclip_ff     <= lres[PCM_W];
                  rclip_ff     <= rres[PCM_W];
                  clip_ff      <= clip_sum[CLIP_W] ? '1 : clip_sum[CLIP_W-1:0];
                  ldone_ff     <= 1'b0;
                  rdone_ff     <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.left_out      = lout_ff;
   assign rsp_ch.right_out     = rout_ff;
   assign rsp_ch.left_clipped  = lclip_ff;
   assign rsp_ch.right_clipped = rclip_ff;
   assign rsp_ch.clip_total    = clip_ff;

   `SBEQ_ASSERT_NEXT(a_frame_launch, req_take && req_ch.kind == KIND_FRAME, state_ff == S_PRE, "frame transfer did not launch the chain")
   `SBEQ_ASSERT_SAME(a_idle_quiet, state_ff == S_IDLE, cell_busy == '0 && !ldone_ff && !rdone_ff, "cells busy while idle")
   `SBEQ_ASSERT_SAME(a_done_both, state_ff == S_DONE, ldone_ff && rdone_ff, "result stage entered before both rows finished")

endmodule
